// ===== sv/perg_pkg.sv =====
// shared types and constants of the pinhole eye ray generator
package perg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_HALF_FOV_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_HALF_FOV_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_VECTOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_VECTOR      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_VECTOR    = 3'd6;

    localparam int SIZE_W   = 13;
    localparam int TAN_W    = 16;
    localparam int TAN_FRAC = 12;
    localparam int VEC_W    = 16;
    localparam int VEC3_W   = 48;
    localparam int VEC_FRAC = 14;
    localparam int M_W      = 31;
    localparam int SQ_W     = 64;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = ROOT_W + 2;

    localparam logic [VEC_W-1:0] ONE_VEC = 16'd16384;

    localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [TAN_W-1:0]  RST_TAN_X        = 16'd4915;
    localparam logic [TAN_W-1:0]  RST_TAN_Y        = 16'd3686;
    localparam logic [VEC3_W-1:0] RST_RIGHT        = 48'h4000_0000_0000;
    localparam logic [VEC3_W-1:0] RST_UP           = 48'h0000_4000_0000;
    localparam logic [VEC3_W-1:0] RST_LOOK         = 48'h0000_0000_C000;

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } flags_t;

    function automatic logic signed [VEC_W-1:0] vec_comp(input logic [VEC3_W-1:0] v,
                                                         input int k);
        return v[VEC3_W-1-VEC_W*k -: VEC_W];
    endfunction

endpackage

// ===== sv/pinhole_eye_ray_generator.sv =====
// top level: pinhole camera primary ray direction per pixel
// Takes one pixel per clock whenever start is high (busy is never raised) and gives one
// unit ray direction per pixel in the same order, marked by done for one cycle. The
// pipeline holds the bit-per-stage offset dividers, the 32-stage square root and the
// 15-stage normalizing dividers. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must write it only while no pixel is in flight, as the block
// itself does not enforce this.
module pinhole_eye_ray_generator #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [COORD_BITS-1:0]           pixel_x,
    input  logic [COORD_BITS-1:0]           pixel_y,
    input  logic                            cfg_we,
    input  logic [perg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [perg_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output logic signed [15:0]              ray_x,
    output logic signed [15:0]              ray_y,
    output logic signed [15:0]              ray_z
);

    localparam int SIZE_W = perg_pkg::SIZE_W;
    localparam int MW     = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
    localparam int DFW    = MW + 1;
    localparam int PW     = perg_pkg::TAN_W + MW;
    localparam int SUMW   = PW + FRAC_BITS + 1;
    localparam int NW     = SUMW - perg_pkg::TAN_FRAC;
    localparam int AW     = NW + 1;
    localparam int PRW    = AW + perg_pkg::VEC_W;
    localparam int DDW    = AW + 18;
    localparam int MAGW   = DDW - 1;
    localparam int CHUNK  = 8;
    localparam int NCH    = (MAGW + CHUNK - 1) / CHUNK;
    localparam int PADW   = NCH * CHUNK;
    localparam int LZW    = $clog2(PADW);
    localparam int M_W    = perg_pkg::M_W;
    localparam int SQP    = 2 * M_W;
    localparam int SQ_W   = perg_pkg::SQ_W;
    localparam int RW     = perg_pkg::ROOT_W;
    localparam int QN     = perg_pkg::VEC_FRAC + 1;
    localparam int NUMW   = M_W + QN + 1;
    localparam int NDW    = RW + 1;
    localparam int VW     = perg_pkg::VEC_W;

    function automatic logic [2:0] lz8(input logic [CHUNK-1:0] b);
        logic [2:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = CHUNK - 1; i >= 0; i--)
        begin
            if (!found)
            begin
                if (b[i])
                begin
                    found = 1'b1;
                end
                else
                begin
                    n = n + 3'd1;
                end
            end
        end
        return n;
    endfunction

    // configuration registers
    logic [SIZE_W-1:0]           width_reg;
    logic [SIZE_W-1:0]           height_reg;
    logic [perg_pkg::TAN_W-1:0]  tanx_reg;
    logic [perg_pkg::TAN_W-1:0]  tany_reg;
    logic [perg_pkg::VEC3_W-1:0] right_reg;
    logic [perg_pkg::VEC3_W-1:0] up_reg;
    logic [perg_pkg::VEC3_W-1:0] look_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= perg_pkg::RST_IMAGE_WIDTH;
            height_reg <= perg_pkg::RST_IMAGE_HEIGHT;
            tanx_reg   <= perg_pkg::RST_TAN_X;
            tany_reg   <= perg_pkg::RST_TAN_Y;
            right_reg  <= perg_pkg::RST_RIGHT;
            up_reg     <= perg_pkg::RST_UP;
            look_reg   <= perg_pkg::RST_LOOK;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                perg_pkg::CFG_IMAGE_WIDTH:    width_reg  <= cfg_data[SIZE_W-1:0];
                perg_pkg::CFG_IMAGE_HEIGHT:   height_reg <= cfg_data[SIZE_W-1:0];
                perg_pkg::CFG_TAN_HALF_FOV_X: tanx_reg   <= cfg_data[perg_pkg::TAN_W-1:0];
                perg_pkg::CFG_TAN_HALF_FOV_Y: tany_reg   <= cfg_data[perg_pkg::TAN_W-1:0];
                perg_pkg::CFG_RIGHT_VECTOR:   right_reg  <= cfg_data[perg_pkg::VEC3_W-1:0];
                perg_pkg::CFG_UP_VECTOR:      up_reg     <= cfg_data[perg_pkg::VEC3_W-1:0];
                perg_pkg::CFG_LOOK_VECTOR:    look_reg   <= cfg_data[perg_pkg::VEC3_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;

    assign w_eff = (width_reg == '0) ? SIZE_W'(1) : width_reg;
    assign h_eff = (height_reg == '0) ? SIZE_W'(1) : height_reg;

    assign busy = 1'b0;

    // valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic v8_reg, v9_reg, v10_reg, v11_reg, v12_reg, v13_reg, v14_reg;
    logic v15_reg, done_reg;

    // offset path
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [DFW-1:0] diff_a, diff_b;
    logic [MW-1:0]         mag_a_reg, mag_b_reg;
    logic                  neg_a2_reg, neg_b2_reg;
    logic [PW-1:0]         prod_a_reg, prod_b_reg;
    logic                  neg_a3_reg, neg_b3_reg;
    logic [SUMW-1:0]       nsum_a, nsum_b;
    logic [NW-1:0]         n_a_reg, n_b_reg;
    logic                  neg_a4_reg, neg_b4_reg;
    logic                  va_q, vb_q, neg_a_q, neg_b_q;
    logic [NW-1:0]         q_a, q_b;
    logic signed [AW-1:0]  a_s_reg, b_s_reg;

    // direction path
    logic signed [PRW-1:0] ar_reg [0:2];
    logic signed [PRW-1:0] bu_reg [0:2];
    logic signed [DDW-1:0] d_reg  [0:2];
    logic [MAGW-1:0]       mag8_reg  [0:2];
    logic [MAGW-1:0]       mag9_reg  [0:2];
    logic [MAGW-1:0]       mag10_reg [0:2];
    logic [2:0]            neg8_reg;
    perg_pkg::flags_t      flags9_reg, flags10_reg, flags11_reg, flags12_reg;
    perg_pkg::flags_t      flags13_reg, flags14_reg;
    logic [PADW-1:0]       or_word;
    logic [NCH-1:0]        nz9_reg;
    logic [2:0]            loc9_reg [0:NCH-1];
    logic [LZW-1:0]        lz_next, lz_reg;
    logic [2:0]            lz_lo_reg;
    logic [PADW-1:0]       sh11_reg [0:2];
    logic [PADW-1:0]       sh_full  [0:2];
    logic [M_W-1:0]        m12_reg  [0:2];
    logic [M_W-1:0]        m13_reg  [0:2];
    logic [M_W-1:0]        m14_reg  [0:2];
    logic [SQP-1:0]        sq_reg   [0:2];
    logic [SQ_W-1:0]       sum_reg;

    // first stages: input transfer, signed numerators, tangent products
    always_comb
    begin
        diff_a = DFW'({px_reg, 1'b1}) - DFW'(w_eff);
        diff_b = DFW'(h_eff) - DFW'({py_reg, 1'b1});
        nsum_a = SUMW'({prod_a_reg, {FRAC_BITS{1'b0}}})
               + SUMW'({w_eff, {(perg_pkg::TAN_FRAC - 1){1'b0}}});
        nsum_b = SUMW'({prod_b_reg, {FRAC_BITS{1'b0}}})
               + SUMW'({h_eff, {(perg_pkg::TAN_FRAC - 1){1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= pixel_x;
        py_reg     <= pixel_y;
        neg_a2_reg <= diff_a[DFW-1];
        neg_b2_reg <= diff_b[DFW-1];
        mag_a_reg  <= diff_a[DFW-1] ? MW'(-diff_a) : MW'(diff_a);
        mag_b_reg  <= diff_b[DFW-1] ? MW'(-diff_b) : MW'(diff_b);
        prod_a_reg <= PW'(tanx_reg) * PW'(mag_a_reg);
        prod_b_reg <= PW'(tany_reg) * PW'(mag_b_reg);
        neg_a3_reg <= neg_a2_reg;
        neg_b3_reg <= neg_b2_reg;
        n_a_reg    <= nsum_a[SUMW-1:perg_pkg::TAN_FRAC];
        n_b_reg    <= nsum_b[SUMW-1:perg_pkg::TAN_FRAC];
        neg_a4_reg <= neg_a3_reg;
        neg_b4_reg <= neg_b3_reg;
    end

    perg_div #(
        .DW (SIZE_W),
        .QW (NW),
        .SW (1)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .rem0      ('0),
        .num       (n_a_reg),
        .den       (w_eff),
        .side_in   (neg_a4_reg),
        .out_valid (va_q),
        .quo       (q_a),
        .side_out  (neg_a_q)
    );

    perg_div #(
        .DW (SIZE_W),
        .QW (NW),
        .SW (1)
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .rem0      ('0),
        .num       (n_b_reg),
        .den       (h_eff),
        .side_in   (neg_b4_reg),
        .out_valid (vb_q),
        .quo       (q_b),
        .side_out  (neg_b_q)
    );

    // signed offsets, basis products, direction sum, magnitudes, leading-zero normalization and sum of squares
    always_comb
    begin
        or_word = PADW'(mag8_reg[0] | mag8_reg[1] | mag8_reg[2]);
        lz_next = '0;
        for (int c = NCH - 1; c >= 0; c--)
        begin
            if (nz9_reg[c])
            begin
                lz_next = LZW'(c * CHUNK) + LZW'(loc9_reg[c]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            sh_full[k] = sh11_reg[k] << lz_lo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_s_reg <= neg_a_q ? -AW'(q_a) : AW'(q_a);
        b_s_reg <= neg_b_q ? -AW'(q_b) : AW'(q_b);
        for (int k = 0; k < 3; k++)
        begin
            ar_reg[k] <= a_s_reg * perg_pkg::vec_comp(right_reg, k);
            bu_reg[k] <= b_s_reg * perg_pkg::vec_comp(up_reg, k);
            d_reg[k]  <= DDW'(ar_reg[k]) + DDW'(bu_reg[k])
                       + (DDW'(perg_pkg::vec_comp(look_reg, k)) <<< FRAC_BITS);
            neg8_reg[k]  <= d_reg[k][DDW-1];
            mag8_reg[k]  <= d_reg[k][DDW-1] ? MAGW'(-d_reg[k]) : MAGW'(d_reg[k]);
            mag9_reg[k]  <= mag8_reg[k];
            mag10_reg[k] <= mag9_reg[k];
            sh11_reg[k]  <= PADW'(mag10_reg[k]) << {lz_reg[LZW-1:3], 3'b000};
            m12_reg[k]   <= sh_full[k][PADW-1 -: M_W];
            m13_reg[k]   <= m12_reg[k];
            sq_reg[k]    <= SQP'(m12_reg[k]) * SQP'(m12_reg[k]);
            m14_reg[k]   <= m13_reg[k];
        end
        for (int c = 0; c < NCH; c++)
        begin
            nz9_reg[c]  <= |or_word[PADW-1-CHUNK*c -: CHUNK];
            loc9_reg[c] <= lz8(or_word[PADW-1-CHUNK*c -: CHUNK]);
        end
        flags9_reg.zero <= ~|or_word;
        flags9_reg.neg  <= neg8_reg;
        flags10_reg     <= flags9_reg;
        lz_reg          <= lz_next;
        flags11_reg     <= flags10_reg;
        lz_lo_reg       <= lz_reg[2:0];
        flags12_reg     <= flags11_reg;
        flags13_reg     <= flags12_reg;
        sum_reg         <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
        flags14_reg     <= flags13_reg;
    end

    // length and normalization
    localparam int ISW = 4 + 3 * M_W;

    logic                 isq_valid;
    logic [RW-1:0]        isq_root;
    logic [ISW-1:0]       isq_side;
    perg_pkg::flags_t     isq_flags;
    logic [M_W-1:0]       isq_m [0:2];
    logic [NUMW-1:0]      n15_reg [0:2];
    logic [NDW-1:0]       den15_reg;
    perg_pkg::flags_t     flags15_reg;

    perg_isqrt #(
        .SW (ISW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v14_reg),
        .radicand  (sum_reg),
        .side_in   ({flags14_reg, m14_reg[0], m14_reg[1], m14_reg[2]}),
        .out_valid (isq_valid),
        .root      (isq_root),
        .side_out  (isq_side)
    );

    assign isq_flags = isq_side[ISW-1 -: 4];
    assign isq_m[0]  = isq_side[3*M_W-1 -: M_W];
    assign isq_m[1]  = isq_side[2*M_W-1 -: M_W];
    assign isq_m[2]  = isq_side[M_W-1:0];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            n15_reg[k] <= NUMW'({isq_m[k], {QN{1'b0}}}) + NUMW'(isq_root);
        end
        den15_reg   <= {isq_root, 1'b0};
        flags15_reg <= isq_flags;
    end

    logic             vx_q, vy_q, vz_q;
    logic [QN-1:0]    qx, qy, qz;
    perg_pkg::flags_t fx_q;
    logic             ny_q, nz_q;

    perg_div #(
        .DW (NDW),
        .QW (QN),
        .SW (4)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v15_reg),
        .rem0      (NDW'(n15_reg[0][NUMW-1:QN])),
        .num       (n15_reg[0][QN-1:0]),
        .den       (den15_reg),
        .side_in   (flags15_reg),
        .out_valid (vx_q),
        .quo       (qx),
        .side_out  (fx_q)
    );

    perg_div #(
        .DW (NDW),
        .QW (QN),
        .SW (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v15_reg),
        .rem0      (NDW'(n15_reg[1][NUMW-1:QN])),
        .num       (n15_reg[1][QN-1:0]),
        .den       (den15_reg),
        .side_in   (flags15_reg.neg[1]),
        .out_valid (vy_q),
        .quo       (qy),
        .side_out  (ny_q)
    );

    perg_div #(
        .DW (NDW),
        .QW (QN),
        .SW (1)
    ) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v15_reg),
        .rem0      (NDW'(n15_reg[2][NUMW-1:QN])),
        .num       (n15_reg[2][QN-1:0]),
        .den       (den15_reg),
        .side_in   (flags15_reg.neg[2]),
        .out_valid (vz_q),
        .quo       (qz),
        .side_out  (nz_q)
    );

    // saturation, sign and output register
    logic          out_valid;
    logic [VW-1:0] rx, ry, rz;
    logic [VW-1:0] ray_x_next, ray_y_next, ray_z_next;
    logic [VW-1:0] ray_x_reg, ray_y_reg, ray_z_reg;

    always_comb
    begin
        out_valid = vx_q & vy_q & vz_q;
        rx = (VW'(qx) > perg_pkg::ONE_VEC) ? perg_pkg::ONE_VEC : VW'(qx);
        ry = (VW'(qy) > perg_pkg::ONE_VEC) ? perg_pkg::ONE_VEC : VW'(qy);
        rz = (VW'(qz) > perg_pkg::ONE_VEC) ? perg_pkg::ONE_VEC : VW'(qz);
        if (fx_q.zero)
        begin
            ray_x_next = '0;
            ray_y_next = '0;
            ray_z_next = '0;
        end
        else
        begin
            ray_x_next = fx_q.neg[0] ? -rx : rx;
            ray_y_next = ny_q ? -ry : ry;
            ray_z_next = nz_q ? -rz : rz;
        end
    end

    always_ff @(posedge clk)
    begin
        ray_x_reg <= ray_x_next;
        ray_y_reg <= ray_y_next;
        ray_z_reg <= ray_z_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            v11_reg  <= 1'b0;
            v12_reg  <= 1'b0;
            v13_reg  <= 1'b0;
            v14_reg  <= 1'b0;
            v15_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start & ~busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= va_q & vb_q;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            v9_reg   <= v8_reg;
            v10_reg  <= v9_reg;
            v11_reg  <= v10_reg;
            v12_reg  <= v11_reg;
            v13_reg  <= v12_reg;
            v14_reg  <= v13_reg;
            v15_reg  <= isq_valid;
            done_reg <= out_valid;
        end
    end

    assign done  = done_reg;
    assign ray_x = ray_x_reg;
    assign ray_y = ray_y_reg;
    assign ray_z = ray_z_reg;

    // normalizer puts the largest magnitude at the top bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (v12_reg && !flags12_reg.zero) |->
            (m12_reg[0][M_W-1] || m12_reg[1][M_W-1] || m12_reg[2][M_W-1]))
        else $error("normalized magnitudes miss the top bit");

    // square root of a normalized nonzero vector has one of its top two bits set
    assert property (@(posedge clk) disable iff (!rst_n)
        (isq_valid && !isq_flags.zero) |-> (isq_root[RW-1:RW-2] != 2'b00))
        else $error("vector length below normalized range");

    // no component can exceed the length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fx_q.zero) |->
            (VW'(qx) <= perg_pkg::ONE_VEC && VW'(qy) <= perg_pkg::ONE_VEC
             && VW'(qz) <= perg_pkg::ONE_VEC))
        else $error("normalized component above one");

    // valid bits of the parallel dividers travel together
    assert property (@(posedge clk) disable iff (!rst_n)
        (va_q == vb_q) && (vx_q == vy_q) && (vy_q == vz_q))
        else $error("parallel divider lanes out of step");

endmodule

// ===== sv/perg_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module perg_div #(
    parameter int DW = 13,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] rem0,
    input  logic [QW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [1:QW];
    logic [DW-1:0] rem_reg   [1:QW];
    logic [QW-1:0] qn_reg    [1:QW];
    logic [DW-1:0] den_reg   [1:QW];
    logic [SW-1:0] side_reg  [1:QW];

    genvar s;
    generate
        for (s = 1; s <= QW; s++)
        begin : g_stage
            logic          v_in;
            logic [DW-1:0] r_in;
            logic [QW-1:0] q_in;
            logic [DW-1:0] d_in;
            logic [SW-1:0] sd_in;
            logic [DW:0]   trial;
            logic          ge;
            logic [DW-1:0] rem_next;
            logic [QW-1:0] qn_next;

            if (s == 1)
            begin : g_first
                assign v_in  = in_valid;
                assign r_in  = rem0;
                assign q_in  = num;
                assign d_in  = den;
                assign sd_in = side_in;
            end
            else
            begin : g_next
                assign v_in  = valid_reg[s-1];
                assign r_in  = rem_reg[s-1];
                assign q_in  = qn_reg[s-1];
                assign d_in  = den_reg[s-1];
                assign sd_in = side_reg[s-1];
            end

            assign trial    = {r_in, q_in[QW-1]};
            assign ge       = trial >= {1'b0, d_in};
            assign rem_next = ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
            assign qn_next  = {q_in[QW-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else
                begin
                    valid_reg[s] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s]  <= rem_next;
                qn_reg[s]   <= qn_next;
                den_reg[s]  <= d_in;
                side_reg[s] <= sd_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[QW];
    assign quo       = qn_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

// ===== sv/perg_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module perg_isqrt #(
    parameter int SW = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [perg_pkg::SQ_W-1:0]   radicand,
    input  logic [SW-1:0]               side_in,
    output logic                        out_valid,
    output logic [perg_pkg::ROOT_W-1:0] root,
    output logic [SW-1:0]               side_out
);

    localparam int RW = perg_pkg::ROOT_W;
    localparam int EW = perg_pkg::REM_W;
    localparam int QW = perg_pkg::SQ_W;

    logic          valid_reg [1:RW];
    logic [EW-1:0] rem_reg   [1:RW];
    logic [RW-1:0] root_reg  [1:RW];
    logic [QW-1:0] rad_reg   [1:RW];
    logic [SW-1:0] side_reg  [1:RW];

    genvar s;
    generate
        for (s = 1; s <= RW; s++)
        begin : g_stage
            logic          v_in;
            logic [EW-1:0] r_in;
            logic [RW-1:0] rt_in;
            logic [QW-1:0] rd_in;
            logic [SW-1:0] sd_in;
            logic [EW+1:0] t;
            logic [EW+1:0] trial;
            logic          ge;
            logic [EW-1:0] rem_next;
            logic [RW-1:0] root_next;

            if (s == 1)
            begin : g_first
                assign v_in  = in_valid;
                assign r_in  = '0;
                assign rt_in = '0;
                assign rd_in = radicand;
                assign sd_in = side_in;
            end
            else
            begin : g_next
                assign v_in  = valid_reg[s-1];
                assign r_in  = rem_reg[s-1];
                assign rt_in = root_reg[s-1];
                assign rd_in = rad_reg[s-1];
                assign sd_in = side_reg[s-1];
            end

            assign t         = {r_in, rd_in[QW-1:QW-2]};
            assign trial     = (EW+2)'({rt_in, 2'b01});
            assign ge        = t >= trial;
            assign rem_next  = ge ? EW'(t - trial) : t[EW-1:0];
            assign root_next = {rt_in[RW-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else
                begin
                    valid_reg[s] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                rad_reg[s]  <= {rd_in[QW-3:0], 2'b00};
                side_reg[s] <= sd_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[RW];
    assign root      = root_reg[RW];
    assign side_out  = side_reg[RW];

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the pinhole eye ray generator
module testbench;
    import perg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int IDLE_LIMIT = 2000;
    localparam int FLUSH_CYCLES = 120;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } ray_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [11:0]           pixel_x = '0;
    logic [11:0]           pixel_y = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  done;
    logic signed [15:0]    ray_x;
    logic signed [15:0]    ray_y;
    logic signed [15:0]    ray_z;

    // camera copy used for prediction
    logic [SIZE_W-1:0] cam_width = RST_IMAGE_WIDTH;
    logic [SIZE_W-1:0] cam_height = RST_IMAGE_HEIGHT;
    logic [TAN_W-1:0]  cam_tan_x = RST_TAN_X;
    logic [TAN_W-1:0]  cam_tan_y = RST_TAN_Y;
    logic [VEC3_W-1:0] cam_right = RST_RIGHT;
    logic [VEC3_W-1:0] cam_up = RST_UP;
    logic [VEC3_W-1:0] cam_look = RST_LOOK;

    ray_t pending_rays[$];
    int   fail_count = 0;
    int   pixels_sent = 0;
    int   rays_checked = 0;
    int   cam_settings = 1;
    int   idle_cycles = 0;
    bit   burst = 1'b0;

    pinhole_eye_ray_generator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_x(pixel_x), .pixel_y(pixel_y),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .ray_x(ray_x), .ray_y(ray_y), .ray_z(ray_z)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint axis_of(logic [VEC3_W-1:0] v, int k);
        logic signed [15:0] c;
        c = v[VEC3_W-1-16*k -: 16];
        return longint'(c);
    endfunction

    // tan * num / size in Q.14, rounded on magnitude
    function automatic longint plane_offset(longint unsigned tanq, longint num,
                                            longint unsigned size);
        longint unsigned m;
        longint unsigned den;
        longint unsigned q;
        m = (num < 0) ? longint'(-num) : longint'(num);
        den = size << TAN_FRAC;
        q = (((tanq * m) << 14) + (den >> 1)) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic ray_t predict_ray(logic [11:0] px, logic [11:0] py);
        longint w;
        longint h;
        longint a;
        longint b;
        longint d;
        longint unsigned mag[3];
        bit neg[3];
        longint unsigned maxm;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned r;
        longint s[3];
        int bl;
        ray_t res;
        w = (cam_width == 0) ? 1 : longint'(cam_width);
        h = (cam_height == 0) ? 1 : longint'(cam_height);
        a = plane_offset(cam_tan_x, 2 * longint'(px) + 1 - w, w);
        b = plane_offset(cam_tan_y, h - 2 * longint'(py) - 1, h);
        maxm = 0;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = a * axis_of(cam_right, k) + b * axis_of(cam_up, k)
                + axis_of(cam_look, k) * 64'sd16384;
            neg[k] = d < 0;
            mag[k] = (d < 0) ? longint'(-d) : longint'(d);
            if (mag[k] > maxm)
                maxm = mag[k];
        end
        if (maxm == 0)
        begin
            res.x = 0;
            res.y = 0;
            res.z = 0;
            return res;
        end
        bl = 0;
        while (bl < 64 && (maxm >> bl) != 0)
            bl++;
        for (int k = 0; k < 3; k++)
        begin
            if (bl > 31)
                mag[k] = mag[k] >> (bl - 31);
            else
                mag[k] = mag[k] << (31 - bl);
            sum = sum + mag[k] * mag[k];
        end
        len = floor_sqrt(sum);
        if (len == 0)
            len = 1;
        for (int k = 0; k < 3; k++)
        begin
            r = ((mag[k] << 15) + len) / (2 * len);
            if (r > 16384)
                r = 16384;
            s[k] = neg[k] ? -longint'(r) : longint'(r);
        end
        res.x = s[0][15:0];
        res.y = s[1][15:0];
        res.z = s[2][15:0];
        return res;
    endfunction

    // result checker and idle watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            if (done)
            begin
                if (pending_rays.size() == 0)
                begin
                    $error("ray result with no pixel outstanding");
                    fail_count++;
                end
                else
                begin
                    ray_t e;
                    e = pending_rays.pop_front();
                    rays_checked++;
                    if (ray_x !== e.x)
                    begin
                        $error("ray_x expected %0d actual %0d", e.x, ray_x);
                        fail_count++;
                    end
                    if (ray_y !== e.y)
                    begin
                        $error("ray_y expected %0d actual %0d", e.y, ray_y);
                        fail_count++;
                    end
                    if (ray_z !== e.z)
                    begin
                        $error("ray_z expected %0d actual %0d", e.z, ray_z);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic send_pixel(logic [11:0] px, logic [11:0] py);
        int gap;
        start <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rays.push_back(predict_ray(px, py));
        pixels_sent++;
        gap = burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and let every outstanding transfer come back
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_rays.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:    cam_width = val[SIZE_W-1:0];
            CFG_IMAGE_HEIGHT:   cam_height = val[SIZE_W-1:0];
            CFG_TAN_HALF_FOV_X: cam_tan_x = val[TAN_W-1:0];
            CFG_TAN_HALF_FOV_Y: cam_tan_y = val[TAN_W-1:0];
            CFG_RIGHT_VECTOR:   cam_right = val;
            CFG_UP_VECTOR:      cam_up = val;
            CFG_LOOK_VECTOR:    cam_look = val;
            default: ;
        endcase
    endtask

    task automatic set_camera(int w, int h, int tx, int ty,
                              logic [47:0] rv, logic [47:0] uv, logic [47:0] lv);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_TAN_HALF_FOV_X, CFG_DATA_W'(tx));
        write_reg(CFG_TAN_HALF_FOV_Y, CFG_DATA_W'(ty));
        write_reg(CFG_RIGHT_VECTOR, rv);
        write_reg(CFG_UP_VECTOR, uv);
        write_reg(CFG_LOOK_VECTOR, lv);
        cam_settings++;
    endtask

    function automatic logic [47:0] rand_vec();
        logic [47:0] v;
        case ($urandom_range(0, 3))
            0: v = RST_RIGHT;
            1: v = RST_UP;
            2: v = RST_LOOK;
            default: v = 48'({$urandom, $urandom});
        endcase
        return v;
    endfunction

    function automatic int rand_size();
        int s;
        case ($urandom_range(0, 5))
            0: s = 1;
            1: s = 4096;
            2: s = 0;
            3: s = $urandom_range(1, 16);
            default: s = $urandom_range(1, 4096);
        endcase
        return s;
    endfunction

    task automatic test_reset_camera;
        burst = 1'b0;
        send_pixel(0, 0);
        send_pixel(639, 479);
        send_pixel(319, 239);
        send_pixel(320, 240);
        send_pixel(639, 0);
        send_pixel(0, 479);
        send_pixel(4095, 4095);
        send_pixel(12'hAAA, 12'h555);
        drain();
    endtask

    task automatic test_corner_cameras;
        burst = 1'b1;
        // zero sizes behave as one pixel
        set_camera(0, 0, 16'hFFFF, 16'hFFFF, RST_RIGHT, RST_UP, RST_LOOK);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        drain();
        // full size and widest field of view
        set_camera(4096, 4096, 16'hFFFF, 16'hFFFF, RST_RIGHT, RST_UP, RST_LOOK);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        send_pixel(2048, 2048);
        drain();
        // zero direction: no tangent and no look vector
        set_camera(1, 1, 0, 0, RST_RIGHT, RST_UP, 48'd0);
        send_pixel(0, 0);
        send_pixel(100, 7);
        drain();
        // unnormalized basis at the extremes of each component
        set_camera(640, 480, 4915, 3686, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000,
                   48'h8000_7FFF_8000);
        write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
        send_pixel(0, 0);
        send_pixel(639, 479);
        send_pixel(4095, 0);
        send_pixel(320, 240);
        drain();
    endtask

    task automatic test_random_scenes;
        int w;
        int h;
        for (int phase = 0; phase < 26; phase++)
        begin
            w = rand_size();
            h = rand_size();
            set_camera(w, h, ($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom_range(0, 16384),
                       ($urandom_range(0, 7) == 0) ? 16'd0 : $urandom_range(0, 65535),
                       rand_vec(), rand_vec(), rand_vec());
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 50; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_pixel(12'($urandom), 12'($urandom));
                else
                    send_pixel(12'($urandom_range(0, (w > 0 ? w : 1) - 1)),
                               12'($urandom_range(0, (h > 0 ? h : 1) - 1)));
            end
            drain();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_camera();
        test_corner_cameras();
        test_random_scenes();
        $display("sent %0d pixels and checked %0d rays over %0d camera settings",
                 pixels_sent, rays_checked, cam_settings);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
